### design/bsgp_pkg.sv
// ----------------------------------------------------------------------------
// bsgp_pkg: shared types and constants of the grid-point batch splitter
// Field widths, save kind codes and the fixed split constants.
// ----------------------------------------------------------------------------
package bsgp_pkg;

  // field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned IV_W   = 21;
  localparam int unsigned KIND_W = 2;

  // largest batch taken as it is; larger sizes are clamped
  localparam int unsigned MAX_BATCH = 2048;
  // distance of the tail point below the final position
  localparam int unsigned TAIL_GAP  = 32;
  // smallest nonzero grid spacing
  localparam int unsigned MIN_GRID  = 64;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // save kind codes
  typedef enum logic [KIND_W-1:0] {
    SAVE_NONE     = 2'd0,
    SAVE_TAIL     = 2'd1,
    SAVE_PERIODIC = 2'd2
  } save_kind_e;

endpackage

### design/bsgp_rem.sv
// ----------------------------------------------------------------------------
// bsgp_rem: bit-serial remainder unit
// Restoring division of a position by the grid spacing, one dividend bit per
// cycle through one shared compare-and-subtract; only the remainder is kept.
// ----------------------------------------------------------------------------
module bsgp_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bsgp_pkg::POS_W-1:0]    dividend_i,
  input  logic [bsgp_pkg::IV_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [bsgp_pkg::IV_W-1:0]     rem_o
);

  localparam int unsigned CNT_W = $clog2(bsgp_pkg::POS_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [bsgp_pkg::POS_W-1:0]  dvd_q;
  logic [bsgp_pkg::IV_W-1:0]   rem_q;
  logic [bsgp_pkg::IV_W-1:0]   div_q;

  logic [bsgp_pkg::IV_W:0]     trial;
  logic                        fits;
  logic [bsgp_pkg::IV_W-1:0]   rem_d;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[bsgp_pkg::POS_W-1]};
    fits  = trial >= {1'b0, div_q};
    if (fits) begin
      rem_d = bsgp_pkg::IV_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[bsgp_pkg::IV_W-1:0];
    end
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(bsgp_pkg::POS_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[bsgp_pkg::POS_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### design/batch_split_at_grid_points_unit.sv
// ----------------------------------------------------------------------------
// batch_split_at_grid_points_unit: splits a token batch at grid points
// Cuts (start, start+size] at multiples of the interval, at the tail point
// and at the end, and emits one sub-batch per cut in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: one beat writes checkpoint_interval; always ready. Write it
//   only while the block is idle.
//   in channel: one beat per batch (start position, size, final position
//   flag, final position). in_ready_o is high only while the sequencer is idle.
//   out channel: one beat per sub-batch; is_last_o marks the final one.
// Timing:
//   With grid cuts on, the first grid point is found first by a bit-serial
//   remainder unit; with the interval at 0 it is skipped. Then one
//   sub-batch is produced per cycle while the receiver keeps up.
//   Up to 34 results per batch. Empty batches give no beat.
// Stall: a result sits in the output register until taken; the sequencer
//   holds its cut state meanwhile, so nothing is lost or repeated.
// Reset: clears the interval to 0 (grid cuts off) and empties the pipeline.
// ----------------------------------------------------------------------------
module batch_split_at_grid_points_unit #(
  parameter int unsigned MAX_BATCH = bsgp_pkg::MAX_BATCH,
  parameter int unsigned TAIL_GAP  = bsgp_pkg::TAIL_GAP
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsgp_pkg::IV_W-1:0]     cfg_data_i,
  // input batches
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bsgp_pkg::POS_W-1:0]    batch_pos_i,
  input  logic [bsgp_pkg::SIZE_W-1:0]   batch_size_i,
  input  logic                          seq_end_vld_i,
  input  logic [bsgp_pkg::POS_W-1:0]    seq_end_pos_i,
  // output sub-batches
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsgp_pkg::SIZE_W-1:0]   sub_size_o,
  output logic [bsgp_pkg::POS_W-1:0]    cut_pos_o,
  output logic [bsgp_pkg::KIND_W-1:0]   save_kind_o,
  output logic                          is_last_o
);

  localparam int unsigned POS_W  = bsgp_pkg::POS_W;
  localparam int unsigned SIZE_W = bsgp_pkg::SIZE_W;
  localparam int unsigned IV_W   = bsgp_pkg::IV_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e state_q;

  // configuration register
  logic [IV_W-1:0] cfg_iv_q;
  logic [IV_W-1:0] iv_eff;

  // per-batch context
  logic [POS_W-1:0] end_q;
  logic [POS_W-1:0] tail_q;
  logic             tail_ok_q;
  logic             seq_end_vld_q;
  logic             grid_on_q;
  logic [IV_W-1:0]  iv_q;
  logic [POS_W-1:0] prev_q;
  logic [POS_W:0]   grid_q;

  // output register
  logic              out_valid_q;
  logic [SIZE_W-1:0] sub_size_q;
  logic [POS_W-1:0]  cut_pos_q;
  logic [1:0]        save_kind_q;
  logic              is_last_q;

  // accept-side decode
  logic              in_fire;
  logic [SIZE_W-1:0] size_cl;
  logic [POS_W:0]    end_sum;
  logic [POS_W-1:0]  end_c;
  logic              empty_c;
  logic              tail_ok_c;

  // remainder unit
  logic             div_start;
  logic             div_done;
  logic [IV_W-1:0]  div_rem;

  // cut selection
  logic [POS_W-1:0] cut_c;
  logic             is_grid;
  logic             is_last_c;
  bsgp_pkg::save_kind_e kind_c;
  logic             out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // small nonzero spacing is raised to the minimum
  always_comb begin
    if (cfg_iv_q != '0 && cfg_iv_q < IV_W'(bsgp_pkg::MIN_GRID)) begin
      iv_eff = IV_W'(bsgp_pkg::MIN_GRID);
    end else begin
      iv_eff = cfg_iv_q;
    end
  end

  // batch end, clamped size and saturated position
  always_comb begin
    if (batch_size_i > SIZE_W'(MAX_BATCH)) begin
      size_cl = SIZE_W'(MAX_BATCH);
    end else begin
      size_cl = batch_size_i;
    end
    end_sum = {1'b0, batch_pos_i} + (POS_W+1)'(size_cl);
    if (end_sum > {1'b0, bsgp_pkg::POS_MAX}) begin
      end_c = bsgp_pkg::POS_MAX;
    end else begin
      end_c = end_sum[POS_W-1:0];
    end
    empty_c   = (batch_size_i == '0) || (end_c <= batch_pos_i);
    tail_ok_c = seq_end_vld_i && (seq_end_pos_i > POS_W'(TAIL_GAP));
  end

  assign div_start = in_fire && !empty_c && (iv_eff != '0);

  bsgp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (batch_pos_i),
    .divisor_i  (iv_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // next cut: earliest of end, grid point and tail point
  always_comb begin
    cut_c = end_q;
    if (grid_on_q && (grid_q < {1'b0, cut_c})) begin
      cut_c = grid_q[POS_W-1:0];
    end
    if (tail_ok_q && (tail_q > prev_q) && (tail_q < cut_c)) begin
      cut_c = tail_q;
    end
    is_grid   = grid_on_q && (grid_q == {1'b0, cut_c});
    is_last_c = (cut_c == end_q);
    if (tail_ok_q && (cut_c == tail_q)) begin
      kind_c = bsgp_pkg::SAVE_TAIL;
    end else if (is_grid && (!seq_end_vld_q || (tail_ok_q && (cut_c < tail_q)))) begin
      kind_c = bsgp_pkg::SAVE_PERIODIC;
    end else begin
      kind_c = bsgp_pkg::SAVE_NONE;
    end
  end

  // sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_iv_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_iv_q <= cfg_data_i;
      end
      // load a result when the slot is free, else drop the one taken
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && !empty_c) begin
            state_q <= (iv_eff != '0) ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free && is_last_c) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // batch context and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      end_q         <= end_c;
      tail_q        <= POS_W'(seq_end_pos_i - POS_W'(TAIL_GAP));
      tail_ok_q     <= tail_ok_c;
      seq_end_vld_q <= seq_end_vld_i;
      grid_on_q     <= (iv_eff != '0);
      iv_q          <= iv_eff;
      prev_q        <= batch_pos_i;
    end
    // first grid point above start: start - (start mod iv) + iv
    if (state_q == ST_DIV && div_done) begin
      grid_q <= {1'b0, prev_q} - (POS_W+1)'(div_rem) + (POS_W+1)'(iv_q);
    end
    if (state_q == ST_EMIT && out_free) begin
      sub_size_q  <= SIZE_W'(cut_c - prev_q);
      cut_pos_q   <= cut_c;
      save_kind_q <= kind_c;
      is_last_q   <= is_last_c;
      prev_q      <= cut_c;
      if (is_grid) begin
        grid_q <= grid_q + (POS_W+1)'(iv_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sub_size_o  = sub_size_q;
  assign cut_pos_o   = cut_pos_q;
  assign save_kind_o = save_kind_q;
  assign is_last_o   = is_last_q;

endmodule

### test/bsgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsgp_checker: scoreboard for the grid-point batch splitter
// Watches the config, batch and sub-batch channels. Each accepted batch is
// split here into its expected sub-batches, and every sub-batch beat from
// the block is checked field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module bsgp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bsgp_pkg::IV_W-1:0]     cfg_data_i,
  // batch channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bsgp_pkg::POS_W-1:0]    batch_pos_i,
  input  logic [bsgp_pkg::SIZE_W-1:0]   batch_size_i,
  input  logic                          seq_end_vld_i,
  input  logic [bsgp_pkg::POS_W-1:0]    seq_end_pos_i,
  // sub-batch channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bsgp_pkg::SIZE_W-1:0]   sub_size_i,
  input  logic [bsgp_pkg::POS_W-1:0]    cut_pos_i,
  input  logic [bsgp_pkg::KIND_W-1:0]   save_kind_i,
  input  logic                          is_last_i,
  // status toward the test top
  output int                            fail_cnt_o,
  output int                            pending_o
);

  localparam int unsigned MAX_CUTS = 34;
  localparam int unsigned POS_W    = bsgp_pkg::POS_W;
  localparam int unsigned SIZE_W   = bsgp_pkg::SIZE_W;
  localparam int unsigned IV_W     = bsgp_pkg::IV_W;

  typedef struct packed {
    logic [SIZE_W-1:0]    sub_size;
    logic [POS_W-1:0]     cut_pos;
    bsgp_pkg::save_kind_e kind;
    logic                 is_last;
  } sub_batch_t;

  logic [IV_W-1:0] interval_q;
  sub_batch_t      cut_q[$];

  // one line per problem, counted
  task automatic report_error(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // split one batch at grid points, tail point and end; queue the sub-batches
  function automatic void split_batch(input logic [POS_W-1:0] start,
                                      input logic [SIZE_W-1:0] size,
                                      input logic has_fin,
                                      input logic [POS_W-1:0] fin);
    int unsigned pos_top, tokens, end_p, iv, tail, grid, prev, c, cnt;
    bit          tail_ok, grid_on;
    sub_batch_t  sb;
    pos_top = int'(bsgp_pkg::POS_MAX);
    if (size == 0) return;
    tokens = (size > bsgp_pkg::MAX_BATCH) ? bsgp_pkg::MAX_BATCH : size;
    end_p  = start + tokens;
    if (end_p > pos_top) end_p = pos_top;
    if (end_p <= start) return;
    // short nonzero spacing is raised to the minimum grid
    iv = interval_q;
    if (iv != 0 && iv < bsgp_pkg::MIN_GRID) iv = bsgp_pkg::MIN_GRID;
    grid_on = (iv != 0);
    tail_ok = has_fin && (fin > bsgp_pkg::TAIL_GAP);
    tail    = tail_ok ? fin - bsgp_pkg::TAIL_GAP : 0;
    grid    = grid_on ? (start / iv + 1) * iv : 0;
    prev    = start;
    cnt     = 0;
    while (prev < end_p && cnt < MAX_CUTS) begin
      c = end_p;
      if (grid_on && grid < c) c = grid;
      if (tail_ok && tail > prev && tail < c) c = tail;
      // tail wins over grid; periodic only below the tail or with no final
      sb.kind = bsgp_pkg::SAVE_NONE;
      if (tail_ok && c == tail) begin
        sb.kind = bsgp_pkg::SAVE_TAIL;
      end else if (grid_on && (c % iv) == 0) begin
        if (!has_fin || (tail_ok && c < tail)) sb.kind = bsgp_pkg::SAVE_PERIODIC;
      end
      sb.sub_size = SIZE_W'(c - prev);
      sb.cut_pos  = POS_W'(c);
      sb.is_last  = (c == end_p);
      cut_q.insert(cut_q.size(), sb);
      cnt++;
      if (grid_on && grid == c) grid += iv;
      prev = c;
    end
  endfunction

  // sample all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    sub_batch_t want;
    if (!rst_ni) begin
      interval_q = '0;
      cut_q.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) interval_q = cfg_data_i;
      // result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (cut_q.size() == 0) begin
          report_error($sformatf("unexpected beat, cut_pos %0d sub_size %0d",
                                 cut_pos_i, sub_size_i));
        end else begin
          want = cut_q.pop_front();
          if (sub_size_i !== want.sub_size)
            report_error($sformatf("cut %0d sub_size got %0d want %0d",
                                   want.cut_pos, sub_size_i, want.sub_size));
          if (cut_pos_i !== want.cut_pos)
            report_error($sformatf("cut_pos got %0d want %0d",
                                   cut_pos_i, want.cut_pos));
          if (save_kind_i !== want.kind)
            report_error($sformatf("cut %0d save_kind got %0d want %0d",
                                   want.cut_pos, save_kind_i, want.kind));
          if (is_last_i !== want.is_last)
            report_error($sformatf("cut %0d is_last got %0b want %0b",
                                   want.cut_pos, is_last_i, want.is_last));
        end
      end
      if (in_valid_i && in_ready_i)
        split_batch(batch_pos_i, batch_size_i, seq_end_vld_i, seq_end_pos_i);
      pending_o <= cut_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: test top for the grid-point batch splitter
// Drives directed and random batches over a range of grid intervals, with
// random gaps on the batch side and random stalls on the sub-batch side.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned POS_W     = bsgp_pkg::POS_W;
  localparam int unsigned SIZE_W    = bsgp_pkg::SIZE_W;
  localparam int unsigned IV_W      = bsgp_pkg::IV_W;
  localparam int unsigned KIND_W    = bsgp_pkg::KIND_W;
  localparam int unsigned POS_LIM   = 24'hFFFFFF;
  localparam int unsigned QUIET_MAX = 5000;
  localparam int unsigned SETTLE    = 64;
  localparam int unsigned PER_PHASE = 13;
  localparam int unsigned NUM_IV    = 10;
  localparam logic [IV_W-1:0] IV_SET [NUM_IV] = '{
    21'd0, 21'd64, 21'd65, 21'd1, 21'd63, 21'd100, 21'd777, 21'd4096,
    21'd1048576, 21'd2097151
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IV_W-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [POS_W-1:0]  batch_pos = '0;
  logic [SIZE_W-1:0] batch_size = '0;
  logic              seq_end_vld = 1'b0;
  logic [POS_W-1:0]  seq_end_pos = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SIZE_W-1:0] sub_size;
  logic [POS_W-1:0]  cut_pos;
  logic [KIND_W-1:0] save_kind;
  logic              is_last;

  int          fail_cnt;
  int          pending;
  int          idle_pct = 37;
  int unsigned batch_cnt = 0;
  int unsigned beat_cnt = 0;
  int unsigned cfg_cnt = 0;
  int unsigned quiet = 0;

  always #5 clk = ~clk;

  batch_split_at_grid_points_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .batch_pos_i   (batch_pos),
    .batch_size_i  (batch_size),
    .seq_end_vld_i (seq_end_vld),
    .seq_end_pos_i (seq_end_pos),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sub_size_o    (sub_size),
    .cut_pos_o     (cut_pos),
    .save_kind_o   (save_kind),
    .is_last_o     (is_last)
  );

  bsgp_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .batch_pos_i   (batch_pos),
    .batch_size_i  (batch_size),
    .seq_end_vld_i (seq_end_vld),
    .seq_end_pos_i (seq_end_pos),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .sub_size_i    (sub_size),
    .cut_pos_i     (cut_pos),
    .save_kind_i   (save_kind),
    .is_last_i     (is_last),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // watchdog on cycles with no beat on any channel; also counts sub-batch beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) beat_cnt++;
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
          (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("%0t ns  no beat for %0d cycles", $time, quiet);
        $display("[batch_split_at_grid_points_unit] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // one batch beat, with random gaps in front
  task automatic send_batch(input logic [POS_W-1:0] s,
                            input logic [SIZE_W-1:0] sz,
                            input logic hf, input logic [POS_W-1:0] fp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    batch_pos   <= s;
    batch_size  <= sz;
    seq_end_vld <= hf;
    seq_end_pos <= fp;
    do @(posedge clk); while (!in_ready);
    batch_cnt++;
  endtask

  // drain, let the block settle, then write the interval
  task automatic set_interval(input logic [IV_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_cnt++;
  endtask

  // random batch aimed at grid points and tail points of the current spacing
  task automatic rand_batch(input int unsigned iv,
                            output logic [POS_W-1:0] s_o,
                            output logic [SIZE_W-1:0] sz_o,
                            output logic hf_o, output logic [POS_W-1:0] fp_o);
    int unsigned sz, eff, st, fp, k, off, sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) sz = 0;
    else if (sel < 3) sz = $urandom_range(bsgp_pkg::MAX_BATCH + 1, 4095);
    else if (sel < 6) sz = $urandom_range(301, bsgp_pkg::MAX_BATCH);
    else sz = $urandom_range(1, 300);
    eff = (sz > bsgp_pkg::MAX_BATCH) ? bsgp_pkg::MAX_BATCH : sz;
    // start: just below a grid point, near the top, or anywhere
    sel = $urandom_range(0, 9);
    if (sel < 5 && iv != 0) begin
      k   = $urandom_range(1, POS_LIM / iv);
      off = $urandom_range(0, eff);
      st  = k * iv;
      st  = (st > off) ? st - off : 0;
    end else if (sel < 7) begin
      st = POS_LIM - $urandom_range(0, 3000);
    end else begin
      st = $urandom() & POS_LIM;
    end
    // final position: tail inside the range, tail on a grid point, tiny, any
    sel = $urandom_range(0, 9);
    if (sel < 6) fp = st + bsgp_pkg::TAIL_GAP + $urandom_range(0, eff + 8);
    else if (sel < 8 && iv != 0) fp = (st / iv + 1) * iv + bsgp_pkg::TAIL_GAP;
    else if (sel == 8) fp = $urandom_range(0, 2 * bsgp_pkg::TAIL_GAP);
    else fp = $urandom() & POS_LIM;
    if (fp > POS_LIM) fp = POS_LIM;
    s_o  = st[POS_W-1:0];
    sz_o = sz[SIZE_W-1:0];
    hf_o = ($urandom_range(0, 3) != 0);
    fp_o = fp[POS_W-1:0];
  endtask

  initial begin
    logic [POS_W-1:0]  s;
    logic [SIZE_W-1:0] sz;
    logic              hf;
    logic [POS_W-1:0]  fp;
    int unsigned       iv_eff;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, grid off (reset value)
    send_batch(24'd0, 12'd0, 1'b0, 24'd0);                // empty batch
    send_batch(24'd0, 12'd1, 1'b0, 24'd0);                // single token
    send_batch(24'd100, 12'd2048, 1'b1, 24'd1000);        // tail inside
    send_batch(24'd5, 12'd4095, 1'b0, 24'hFFFFFF);        // oversized size
    send_batch(24'hFFFFFF, 12'd10, 1'b0, 24'd0);          // start at the top
    send_batch(24'd16777000, 12'd2048, 1'b1, 24'd20);     // end saturates
    send_batch(24'd0, 12'd100, 1'b1, 24'd32);             // final not past the gap
    send_batch(24'd16777175, 12'd100, 1'b1, 24'hFFFFFF);  // tail near the top

    // directed, short spacing raised to the minimum grid
    set_interval(21'd1);
    send_batch(24'd0, 12'd2048, 1'b0, 24'd0);             // all periodic
    send_batch(24'd10, 12'd2048, 1'b1, 24'd1000);         // periodic, tail, none
    send_batch(24'd63, 12'd1, 1'b0, 24'd0);               // grid point is the end
    send_batch(24'd0, 12'd300, 1'b1, 24'd20);             // final, no tail point
    send_batch(24'd0, 12'd300, 1'b1, 24'd160);            // tail on a grid point
    send_batch(24'd0, 12'd128, 1'b1, 24'd160);            // tail is the end
    send_batch(24'd200, 12'd100, 1'b1, 24'd100);          // tail below the start
    send_batch(24'd1, 12'd2048, 1'b1, 24'd1033);          // most sub-batches
    send_batch(24'd16777115, 12'd2048, 1'b0, 24'd0);      // grid near the top
    send_batch(24'hFFFFFF, 12'd5, 1'b1, 24'hFFFFFF);      // no room, grid on

    // directed, widest spacings
    set_interval(21'd2097151);
    send_batch(24'd2097150, 12'd10, 1'b0, 24'd0);
    send_batch(24'd0, 12'd2048, 1'b0, 24'd0);
    set_interval(21'd1048576);
    send_batch(24'd1048570, 12'd100, 1'b1, 24'd1048640);

    // random phases over the interval set; one phase with no idling
    for (int p = 0; p < NUM_IV; p++) begin
      set_interval(IV_SET[p]);
      iv_eff   = IV_SET[p];
      if (iv_eff != 0 && iv_eff < bsgp_pkg::MIN_GRID) iv_eff = bsgp_pkg::MIN_GRID;
      idle_pct = (p == 3) ? 0 : 37;
      for (int i = 0; i < PER_PHASE; i++) begin
        rand_batch(iv_eff, s, sz, hf, fp);
        send_batch(s, sz, hf, fp);
      end
    end
    idle_pct = 37;

    // wait out the remaining sub-batches, then a settle window
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d batches over %0d interval writes, %0d sub-batches checked.",
             batch_cnt, cfg_cnt, beat_cnt);
    $display("Mismatches: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("[batch_split_at_grid_points_unit] OK");
    end else begin
      $display("[batch_split_at_grid_points_unit] ERROR");
    end
    $finish;
  end

endmodule
